// ===== sv/pip_pkg.sv =====
// Shared constants, types and helpers for the point-in-polygon winding tester.
package pip_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_BITS   = 16;
   localparam int IN_BITS      = 16;
   localparam int VCOUNT_BITS  = 5;
   localparam int MIN_VERTICES = 3;

   localparam int IDX_BITS  = $clog2(MAX_VERTICES);
   localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int POS_BITS  = $clog2(MAX_VERTICES + 3);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int WIND_BITS = CNT_BITS + 1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [PROD_BITS:0]    sum_type;

   typedef struct packed {
      logic     has_edge;
      logic     has_turn;
      logic     orient;
      diff_type ax;
      diff_type ay;
      diff_type bx;
      diff_type by;
      diff_type e1x;
      diff_type e1y;
      diff_type e2x;
      diff_type e2y;
   } diff_stage_type;

   typedef struct packed {
      logic     has_edge;
      logic     has_turn;
      logic     orient;
      logic     ay_neg;
      logic     by_neg;
      prod_type cp1;
      prod_type cp2;
      prod_type dp1;
      prod_type dp2;
      prod_type tp1;
      prod_type tp2;
   } prod_stage_type;

   function automatic coord_type coord_in(input logic signed [IN_BITS-1:0] v);
      return COORD_BITS'(v);
   endfunction

endpackage

// ===== sv/point_in_polygon_winding.sv =====
// Point-in-polygon tester: vertex memory, query walk pipeline and result register.
// Clear, append, unused command and a query on fewer than three vertices skip the walk and
// go to the result register. A query on n >= 3 vertices walks the polygon, and no new request
// is taken until its result is registered; the single read port of the vertex memory streams
// n + 2 entries through a three-stage difference, multiply and accumulate pipeline.
// Synchronous active-high reset clears the vertex count and control; the memory is not cleared.
module point_in_polygon_winding import pip_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic signed [IN_BITS-1:0]  req_point_x,
   input  logic signed [IN_BITS-1:0]  req_point_y,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_inside_res,
   output logic                       rsp_convex,
   output logic                       rsp_polygon_valid,
   output logic [VCOUNT_BITS-1:0]     rsp_vertex_count,
   output logic                       rsp_rejected
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   coord_type               px_ff, px_in, py_ff, py_in;

   logic                    res_inside_ff, res_inside_in;
   logic                    res_convex_ff, res_convex_in;
   logic                    res_rejected_ff, res_rejected_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_inside_ff, rsp_inside_in;
   logic                    rsp_convex_ff, rsp_convex_in;
   logic                    rsp_pvalid_ff, rsp_pvalid_in;
   logic [VCOUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                    rsp_rejected_ff, rsp_rejected_in;

   logic [2*COORD_BITS-1:0] vtx_mem [MAX_VERTICES];
   logic [2*COORD_BITS-1:0] rdat_ff;
   logic                    rd_en, wr_en;
   logic [IDX_BITS-1:0]     rd_addr;
   logic [POS_BITS-1:0]     rd_wrap;

   logic                    s1_valid_ff, s1_valid_in;
   logic [POS_BITS-1:0]     s1_pos_ff, s1_pos_in;
   coord_type               w0x_ff, w0x_in, w0y_ff, w0y_in;
   coord_type               w1x_ff, w1x_in, w1y_ff, w1y_in;
   coord_type               curx, cury;

   logic                    s2_valid_ff, s2_valid_in;
   diff_stage_type          s2_ff, s2_in;
   logic                    s3_valid_ff, s3_valid_in;
   prod_stage_type          s3_ff, s3_in;

   logic                    on_edge_ff, on_edge_in;
   logic signed [WIND_BITS-1:0] wind_ff, wind_in;
   logic                    left_ff, left_in;
   logic                    neg_any_ff, neg_any_in;
   logic                    pos_any_ff, pos_any_in;

   sum_type                 cval, dval, tval;
   logic                    accept, out_free, issue_more, pipe_empty;
   logic                    wind_pos, wind_neg, inside_q, convex_q;

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign issue_more        = pos_ff < (POS_BITS'(count_ff) + POS_BITS'(2));
   assign pipe_empty        = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;

   assign rd_wrap = pos_ff - POS_BITS'(count_ff);
   assign rd_addr = (pos_ff < POS_BITS'(count_ff)) ? pos_ff[IDX_BITS-1:0]
                                                   : rd_wrap[IDX_BITS-1:0];

   assign curx = coord_type'(rdat_ff[2*COORD_BITS-1:COORD_BITS]);
   assign cury = coord_type'(rdat_ff[COORD_BITS-1:0]);

   assign cval = sum_type'(s3_ff.cp1) - sum_type'(s3_ff.cp2);
   assign dval = sum_type'(s3_ff.dp1) + sum_type'(s3_ff.dp2);
   assign tval = sum_type'(s3_ff.tp1) - sum_type'(s3_ff.tp2);

   assign wind_neg = wind_ff[WIND_BITS-1];
   assign wind_pos = !wind_ff[WIND_BITS-1] && (wind_ff != '0);
   assign inside_q = on_edge_ff || (wind_ff[0] && (left_ff ? wind_pos : wind_neg));
   assign convex_q = left_ff ? !neg_any_ff : !pos_any_ff;

   // control and command handling
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      res_inside_in   = res_inside_ff;
      res_convex_in   = res_convex_ff;
      res_rejected_in = res_rejected_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_inside_in   = rsp_inside_ff;
      rsp_convex_in   = rsp_convex_ff;
      rsp_pvalid_in   = rsp_pvalid_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rd_en           = 1'b0;
      wr_en           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in           = coord_in(req_point_x);
               py_in           = coord_in(req_point_y);
               res_inside_in   = 1'b0;
               res_convex_in   = 1'b0;
               res_rejected_in = 1'b0;
               state_in        = ST_FINISH;
               unique case (req_cmd)
                  CMD_CLEAR: count_in = '0;
                  CMD_APPEND: begin
                     if (count_ff < CNT_BITS'(MAX_VERTICES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_BITS'(1);
                     end else begin
                        res_rejected_in = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff >= CNT_BITS'(MIN_VERTICES)) begin
                        state_in = ST_WALK;
                        pos_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (issue_more) begin
               rd_en  = 1'b1;
               pos_in = pos_ff + POS_BITS'(1);
            end else if (pipe_empty) begin
               res_inside_in = inside_q;
               res_convex_in = convex_q;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_inside_in   = res_inside_ff;
               rsp_convex_in   = res_convex_ff;
               rsp_rejected_in = res_rejected_ff;
               rsp_pvalid_in   = count_ff >= CNT_BITS'(MIN_VERTICES);
               rsp_count_in    = VCOUNT_BITS'(count_ff);
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // difference and multiply stages
   always_comb begin
      s1_valid_in = rd_en;
      s1_pos_in   = pos_ff;
      w0x_in      = w0x_ff;
      w0y_in      = w0y_ff;
      w1x_in      = w1x_ff;
      w1y_in      = w1y_ff;
      if (s1_valid_ff) begin
         w0x_in = w1x_ff;
         w0y_in = w1y_ff;
         w1x_in = curx;
         w1y_in = cury;
      end

      s2_valid_in     = s1_valid_ff;
      s2_in.has_edge  = (s1_pos_ff != '0) && (s1_pos_ff <= POS_BITS'(count_ff));
      s2_in.has_turn  = s1_pos_ff >= POS_BITS'(2);
      s2_in.orient    = s1_pos_ff == POS_BITS'(2);
      s2_in.ax        = diff_type'(w1x_ff) - diff_type'(px_ff);
      s2_in.ay        = diff_type'(w1y_ff) - diff_type'(py_ff);
      s2_in.bx        = diff_type'(curx) - diff_type'(px_ff);
      s2_in.by        = diff_type'(cury) - diff_type'(py_ff);
      s2_in.e1x       = diff_type'(w1x_ff) - diff_type'(w0x_ff);
      s2_in.e1y       = diff_type'(w1y_ff) - diff_type'(w0y_ff);
      s2_in.e2x       = diff_type'(curx) - diff_type'(w1x_ff);
      s2_in.e2y       = diff_type'(cury) - diff_type'(w1y_ff);

      s3_valid_in     = s2_valid_ff;
      s3_in.has_edge  = s2_ff.has_edge;
      s3_in.has_turn  = s2_ff.has_turn;
      s3_in.orient    = s2_ff.orient;
      s3_in.ay_neg    = s2_ff.ay[DIFF_BITS-1];
      s3_in.by_neg    = s2_ff.by[DIFF_BITS-1];
      s3_in.cp1       = s2_ff.ax * s2_ff.by;
      s3_in.cp2       = s2_ff.ay * s2_ff.bx;
      s3_in.dp1       = s2_ff.ax * s2_ff.bx;
      s3_in.dp2       = s2_ff.ay * s2_ff.by;
      s3_in.tp1       = s2_ff.e1x * s2_ff.e2y;
      s3_in.tp2       = s2_ff.e1y * s2_ff.e2x;
   end

   // accumulate winding, boundary and turn flags
   always_comb begin
      on_edge_in = on_edge_ff;
      wind_in    = wind_ff;
      left_in    = left_ff;
      neg_any_in = neg_any_ff;
      pos_any_in = pos_any_ff;
      if (accept) begin
         on_edge_in = 1'b0;
         wind_in    = '0;
         left_in    = 1'b0;
         neg_any_in = 1'b0;
         pos_any_in = 1'b0;
      end else if (s3_valid_ff) begin
         if (s3_ff.has_edge) begin
            if ((cval == sum_type'(0)) && (dval <= sum_type'(0))) begin
               on_edge_in = 1'b1;
            end
            if (s3_ff.ay_neg && !s3_ff.by_neg && (cval > sum_type'(0))) begin
               wind_in = wind_ff + WIND_BITS'(1);
            end else if (s3_ff.by_neg && !s3_ff.ay_neg && (cval < sum_type'(0))) begin
               wind_in = wind_ff - WIND_BITS'(1);
            end
         end
         if (s3_ff.has_turn) begin
            if (s3_ff.orient) begin
               left_in = tval > sum_type'(0);
            end else begin
               if (tval < sum_type'(0)) neg_any_in = 1'b1;
               if (tval > sum_type'(0)) pos_any_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vtx_mem[count_ff[IDX_BITS-1:0]] <= {px_in, py_in};
      end
      if (rd_en) begin
         rdat_ff <= vtx_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff          <= pos_in;
      px_ff           <= px_in;
      py_ff           <= py_in;
      res_inside_ff   <= res_inside_in;
      res_convex_ff   <= res_convex_in;
      res_rejected_ff <= res_rejected_in;
      rsp_inside_ff   <= rsp_inside_in;
      rsp_convex_ff   <= rsp_convex_in;
      rsp_pvalid_ff   <= rsp_pvalid_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_rejected_ff <= rsp_rejected_in;
      s1_pos_ff       <= s1_pos_in;
      w0x_ff          <= w0x_in;
      w0y_ff          <= w0y_in;
      w1x_ff          <= w1x_in;
      w1y_ff          <= w1y_in;
      s2_ff           <= s2_in;
      s3_ff           <= s3_in;
      on_edge_ff      <= on_edge_in;
      wind_ff         <= wind_in;
      left_ff         <= left_in;
      neg_any_ff      <= neg_any_in;
      pos_any_ff      <= pos_any_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inside_res    = rsp_inside_ff;
   assign rsp_convex        = rsp_convex_ff;
   assign rsp_polygon_valid = rsp_pvalid_ff;
   assign rsp_vertex_count  = rsp_count_ff;
   assign rsp_rejected      = rsp_rejected_ff;

endmodule

// ===== sv/pip_checker.sv =====
// Port-level checker for the point-in-polygon tester, bound to the top level.
module pip_checker import pip_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_inside_res,
   input logic                      rsp_convex,
   input logic                      rsp_polygon_valid,
   input logic [VCOUNT_BITS-1:0]    rsp_vertex_count,
   input logic                      rsp_rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_inside_res, rsp_convex, rsp_polygon_valid, rsp_vertex_count,
                  rsp_rejected}))
      else $error("stalled transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   a_inside_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_polygon_valid)
      else $error("inside on polygon with fewer than three vertices");

   a_convex_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_convex |-> rsp_polygon_valid)
      else $error("convex on polygon with fewer than three vertices");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !rsp_inside_res && !rsp_convex)
      else $error("rejected append reports query flags");

endmodule

bind point_in_polygon_winding pip_checker u_pip_checker (.*);

// ===== dv/point_in_polygon_winding_test.sv =====
// Self-checking testbench for the point-in-polygon winding tester: directed and random polygons and queries.
`timescale 1ns / 1ps

module point_in_polygon_winding_test;
   import pip_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 1400;
   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         SETTLE_CYCLES = 32;

   typedef struct {
      logic [1:0]                cmd;
      logic signed [IN_BITS-1:0] x;
      logic signed [IN_BITS-1:0] y;
      bit                        drain;
   } pip_request_type;

   typedef struct {
      bit                   in_poly;
      bit                   convex;
      bit                   poly_ok;
      bit [VCOUNT_BITS-1:0] count;
      bit                   rejected;
   } pip_verdict_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_cmd = CMD_CLEAR;
   logic signed [IN_BITS-1:0] req_point_x = '0;
   logic signed [IN_BITS-1:0] req_point_y = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_inside_res;
   logic                      rsp_convex;
   logic                      rsp_polygon_valid;
   logic [VCOUNT_BITS-1:0]    rsp_vertex_count;
   logic                      rsp_rejected;

   pip_request_type command_q[$];
   pip_verdict_type verdict_q[$];
   int           accepted_count = 0;
   int           total_count = 0;
   int           useful_items = 0;
   int           fail_count = 0;
   int           cycle_count = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   bit           send_calm = 1'b0;
   bit           recv_calm = 1'b0;
   bit           in_random = 1'b0;
   bit           drain_pending = 1'b0;

   coord_type    shadow_x[MAX_VERTICES];
   coord_type    shadow_y[MAX_VERTICES];
   int           shadow_count = 0;

   int           poly_x[$];
   int           poly_y[$];

   point_in_polygon_winding dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inside_res    (rsp_inside_res),
      .rsp_convex        (rsp_convex),
      .rsp_polygon_valid (rsp_polygon_valid),
      .rsp_vertex_count  (rsp_vertex_count),
      .rsp_rejected      (rsp_rejected)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint turn_at_vertex(int a, int b, int c);
      longint e1x, e1y, e2x, e2y;
      e1x = longint'(shadow_x[b]) - longint'(shadow_x[a]);
      e1y = longint'(shadow_y[b]) - longint'(shadow_y[a]);
      e2x = longint'(shadow_x[c]) - longint'(shadow_x[b]);
      e2y = longint'(shadow_y[c]) - longint'(shadow_y[b]);
      return e1x * e2y - e1y * e2x;
   endfunction

   function automatic bit turns_agree(int n, bit ccw);
      longint t;
      for (int i = 1; i < n; i++) begin
         t = turn_at_vertex(i, (i + 1) % n, (i + 2) % n);
         if (ccw && t < 0) return 1'b0;
         if (!ccw && t > 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit point_enclosed(int n, bit ccw, coord_type px, coord_type py);
      int     winding;
      int     j;
      longint ax, ay, bx, by, c, d;
      winding = 0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         ax = longint'(shadow_x[i]) - longint'(px);
         ay = longint'(shadow_y[i]) - longint'(py);
         bx = longint'(shadow_x[j]) - longint'(px);
         by = longint'(shadow_y[j]) - longint'(py);
         c = ax * by - ay * bx;
         d = ax * bx + ay * by;
         if (c == 0 && d <= 0) return 1'b1;
         if (ay < 0 && by >= 0 && c > 0) winding++;
         else if (by < 0 && ay >= 0 && c < 0) winding--;
      end
      if (!ccw) winding = -winding;
      return winding > 0 && (winding % 2) == 1;
   endfunction

   function automatic pip_verdict_type apply_command(logic [1:0] cmd, coord_type px,
                                                     coord_type py);
      pip_verdict_type v;
      bit              ccw;
      v = '{default: 0};
      case (cmd)
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         CMD_APPEND: begin
            if (shadow_count < MAX_VERTICES) begin
               shadow_x[shadow_count] = px;
               shadow_y[shadow_count] = py;
               shadow_count++;
            end else begin
               v.rejected = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (shadow_count >= MIN_VERTICES) begin
               ccw = turn_at_vertex(0, 1, 2) > 0;
               v.in_poly = point_enclosed(shadow_count, ccw, px, py);
               v.convex = turns_agree(shadow_count, ccw);
            end
         end
         default: begin
         end
      endcase
      v.poly_ok = shadow_count >= MIN_VERTICES;
      v.count = VCOUNT_BITS'(shadow_count);
      return v;
   endfunction

   function automatic logic signed [IN_BITS-1:0] clip16(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return IN_BITS'(v);
   endfunction

   task automatic queue_command(logic [1:0] cmd, logic signed [IN_BITS-1:0] x,
                                logic signed [IN_BITS-1:0] y);
      pip_request_type r;
      r.cmd = cmd;
      r.x = x;
      r.y = y;
      r.drain = drain_pending || (in_random && $urandom_range(0, 63) == 0);
      drain_pending = 1'b0;
      command_q.push_back(r);
      total_count++;
      if (cmd != CMD_UNUSED) useful_items++;
   endtask

   task automatic append_vertex(int x, int y);
      queue_command(CMD_APPEND, clip16(x), clip16(y));
      if (poly_x.size() < MAX_VERTICES) begin
         poly_x.push_back(int'(clip16(x)));
         poly_y.push_back(int'(clip16(y)));
      end
   endtask

   task automatic forget_polygon();
      poly_x.delete();
      poly_y.delete();
   endtask

   always @(posedge clock) begin
      pip_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict_q.push_back(apply_command(req_cmd, coord_type'(req_point_x),
                                              coord_type'(req_point_y)));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (command_q.size() == 0 ||
                         (command_q[0].drain && verdict_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               r = command_q.pop_front();
               req_valid <= 1'b1;
               req_cmd <= r.cmd;
               req_point_x <= r.x;
               req_point_y <= r.y;
               if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
               send_gap <= send_calm ? 0 : $urandom_range(0, 7);
            end
         end
      end
   end

   always @(posedge clock) begin
      pip_verdict_type want;
      int              hold;
      hold = stall_left;
      if (reset) begin
         hold = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("result arrived with no transaction outstanding");
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_inside_res !== want.in_poly) begin
               $error("inside_res expected %0d got %0d", want.in_poly, rsp_inside_res);
               fail_count++;
            end
            if (rsp_convex !== want.convex) begin
               $error("convex expected %0d got %0d", want.convex, rsp_convex);
               fail_count++;
            end
            if (rsp_polygon_valid !== want.poly_ok) begin
               $error("polygon_valid expected %0d got %0d", want.poly_ok, rsp_polygon_valid);
               fail_count++;
            end
            if (rsp_vertex_count !== want.count) begin
               $error("vertex_count expected %0d got %0d", want.count, rsp_vertex_count);
               fail_count++;
            end
            if (rsp_rejected !== want.rejected) begin
               $error("rejected expected %0d got %0d", want.rejected, rsp_rejected);
               fail_count++;
            end
         end
         if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
         hold = recv_calm ? 0 : $urandom_range(0, 7);
      end else if (rsp_valid && hold > 0) begin
         hold--;
      end
      stall_left <= hold;
      rsp_stall <= hold > 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("point_in_polygon_winding verification failed");
         $finish;
      end
   end

   initial begin
      int dx[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
      int dy[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
      int base, roll, shape, k, c, nv, nq, pick, i, j, d;
      int cx, cy, r, start, cw, x, y, lo_x, hi_x, lo_y, hi_y, margin;
      int ext_q[$];

      // directed: extreme square, clockwise triangle, collinear first turn, unused command
      queue_command(CMD_QUERY, 16'sd0, 16'sd0);
      queue_command(CMD_UNUSED, 16'sd0, 16'sd0);
      append_vertex(-32768, -32768);
      append_vertex(32767, -32768);
      append_vertex(32767, 32767);
      append_vertex(-32768, 32767);
      queue_command(CMD_QUERY, 16'sd0, 16'sd0);
      queue_command(CMD_QUERY, 16'sh7fff, 16'sd0);
      queue_command(CMD_QUERY, 16'sh8000, 16'sh8000);
      queue_command(CMD_CLEAR, 16'sh7fff, 16'sh8000);
      append_vertex(0, 0);
      append_vertex(0, 10);
      append_vertex(10, 0);
      queue_command(CMD_QUERY, 16'sd2, 16'sd2);
      queue_command(CMD_QUERY, 16'sd20, 16'sd20);
      queue_command(CMD_CLEAR, 16'sd0, 16'sd0);
      append_vertex(0, 0);
      append_vertex(5, 0);
      append_vertex(10, 0);
      append_vertex(10, 10);
      append_vertex(0, 10);
      queue_command(CMD_QUERY, 16'sd5, 16'sd5);
      queue_command(CMD_QUERY, 16'sd0, 16'sd0);
      queue_command(CMD_UNUSED, -16'sd1, -16'sd1);
      forget_polygon();

      in_random = 1'b1;
      drain_pending = 1'b1;
      base = useful_items;
      while (useful_items - base < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            k = $urandom_range(1, 4);
            repeat (k) begin
               c = $urandom_range(0, 3);
               queue_command(c[1:0], IN_BITS'($urandom), IN_BITS'($urandom));
            end
            forget_polygon();
            continue;
         end
         if ($urandom_range(0, 9) != 0) begin
            queue_command(CMD_CLEAR, IN_BITS'($urandom), IN_BITS'($urandom));
            forget_polygon();
         end
         shape = $urandom_range(0, 9);
         if (shape < 4) begin
            cx = $urandom_range(0, 40000) - 20000;
            cy = $urandom_range(0, 40000) - 20000;
            r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 10000);
            start = $urandom_range(0, 7);
            cw = $urandom_range(0, 1);
            for (k = 0; k < 8; k++) begin
               d = cw ? (start - k) & 7 : (start + k) & 7;
               if ($urandom_range(0, 3) != 0) append_vertex(cx + dx[d] * r, cy + dy[d] * r);
            end
         end else if (shape < 7) begin
            cx = $urandom_range(0, 60000) - 30000;
            cy = $urandom_range(0, 60000) - 30000;
            nv = $urandom_range(0, 8);
            repeat (nv) append_vertex(cx + $urandom_range(0, 8) - 4, cy + $urandom_range(0, 8) - 4);
         end else if (shape < 9) begin
            nv = $urandom_range(3, 10);
            repeat (nv) append_vertex(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
         end else begin
            nv = $urandom_range(14, 19);
            repeat (nv) append_vertex($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
         end
         nq = $urandom_range(1, 8);
         repeat (nq) begin
            pick = $urandom_range(0, 9);
            if (poly_x.size() == 0 || pick == 0) begin
               x = int'($signed(16'($urandom)));
               y = int'($signed(16'($urandom)));
            end else if (pick < 3) begin
               i = $urandom_range(0, poly_x.size() - 1);
               x = poly_x[i];
               y = poly_y[i];
            end else if (pick < 5) begin
               i = $urandom_range(0, poly_x.size() - 1);
               j = (i + 1) % poly_x.size();
               x = (poly_x[i] + poly_x[j]) / 2;
               y = (poly_y[i] + poly_y[j]) / 2;
            end else if (pick == 5) begin
               x = $urandom_range(0, 1) ? -32768 : 32767;
               y = $urandom_range(0, 1) ? -32768 : 32767;
            end else begin
               ext_q = poly_x.min();
               lo_x = ext_q[0];
               ext_q = poly_x.max();
               hi_x = ext_q[0];
               ext_q = poly_y.min();
               lo_y = ext_q[0];
               ext_q = poly_y.max();
               hi_y = ext_q[0];
               margin = 2 + (hi_x - lo_x + hi_y - lo_y) / 8;
               x = lo_x - margin + $urandom_range(0, hi_x - lo_x + 2 * margin);
               y = lo_y - margin + $urandom_range(0, hi_y - lo_y + 2 * margin);
            end
            queue_command(CMD_QUERY, clip16(x), clip16(y));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_count || verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdict_q.size() == 0) begin
         $display("point_in_polygon_winding verification clean");
      end else begin
         $display("point_in_polygon_winding verification failed");
      end
      $finish;
   end

endmodule
